[rtl/ssh_pkg.sv]
package ssh_pkg;

	localparam int NUM_SCORES_IN = 3;
	localparam int HIST_W = 32;
	localparam int SCORE_FRAC_W = 16;

	// 0.999 in Q0.16, rounded down.
	localparam logic [15:0] CLAMP_Q16 = 16'd65470;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic RES_IMAGE = 1'b0;
	localparam logic RES_BIN = 1'b1;

	localparam logic [1:0] SET_MAX_CLASS = 2'd0;
	localparam logic [1:0] SET_ABOVE = 2'd1;
	localparam logic [1:0] SET_PER_IMAGE = 2'd2;

	typedef struct packed {
		logic kind;
		logic signed [15:0] pixel_value;
		logic [NUM_SCORES_IN-1:0][15:0] score;
		logic last;
		logic [1:0] read_set;
		logic [1:0] read_class;
		logic [5:0] read_bin;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [HIST_W-1:0] count;
	} result_t;

endpackage

[rtl/ssh_ram.sv]
module ssh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/ssh_bank.sv]
module ssh_bank #(
	parameter int DEPTH = 50,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic inc,
	input logic [AW-1:0] addr,
	output logic [ssh_pkg::HIST_W-1:0] data
);

	logic inc_s4;
	logic [AW-1:0] addr_s4;
	logic [DEPTH-1:0] vld_q;
	logic wr_v_q;
	logic [AW-1:0] wr_addr_q;
	logic [ssh_pkg::HIST_W-1:0] wr_data_q;
	logic [ssh_pkg::HIST_W-1:0] rdata;
	logic [ssh_pkg::HIST_W-1:0] wdata;
	logic fwd;
	logic we;

	ssh_ram #(
		.WIDTH(ssh_pkg::HIST_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(addr_s4),
		.wdata(wdata),
		.re(adv),
		.raddr(addr),
		.rdata(rdata)
	);

	// The write of the previous transaction lands at the same edge as this
	// read, so the RAM misses it and it is taken from the write register.
	assign fwd = wr_v_q && (wr_addr_q == addr_s4);
	assign data = fwd ? wr_data_q : (vld_q[addr_s4] ? rdata : '0);
	assign wdata = (&data) ? data : data + 1'b1;
	assign we = adv && inc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s4 <= 1'b0;
			vld_q <= '0;
			wr_v_q <= 1'b0;
		end else if (adv) begin
			inc_s4 <= inc;
			wr_v_q <= we;
			if (we) begin
				vld_q[addr_s4] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s4 <= addr;
			wr_addr_q <= addr_s4;
			wr_data_q <= wdata;
		end
	end

endmodule

[rtl/ssh_cbin.sv]
module ssh_cbin #(
	parameter int SCORE_BINS = 50,
	parameter int COUNT_RANGE = 500,
	localparam int CR_W = $clog2(COUNT_RANGE),
	localparam int SB_W = $clog2(SCORE_BINS + 1)
) (
	input logic clk,
	input logic adv,
	input logic [CR_W-1:0] n,
	input logic ovf,
	output logic [SB_W-1:0] bin
);

	localparam int SBIN_W = $clog2(SCORE_BINS);
	localparam int SH = CR_W + 1;
	localparam int C_W = SBIN_W + 2;
	localparam longint RECIP = (longint'(SCORE_BINS) << SH) / longint'(COUNT_RANGE);
	localparam int PW = SB_W + CR_W + 1;

	logic [CR_W+C_W-1:0] prod;
	logic [CR_W+SB_W-1:0] x_w;
	logic [SBIN_W-1:0] q0_s3;
	logic [CR_W+SB_W-1:0] x_s3;
	logic ovf_s3;
	logic [SB_W-1:0] nxt;
	logic [PW-1:0] thr;

	// The reciprocal estimate is low by at most one; the next stage fixes it.
	assign prod = n * C_W'(RECIP);
	assign x_w = n * SB_W'(SCORE_BINS);

	always_ff @(posedge clk) begin
		if (adv) begin
			q0_s3 <= prod[SH +: SBIN_W];
			x_s3 <= x_w;
			ovf_s3 <= ovf;
		end
	end

	assign nxt = SB_W'(q0_s3) + 1'b1;
	assign thr = PW'(nxt) * PW'(COUNT_RANGE);

	always_comb begin
		if (ovf_s3) begin
			bin = SB_W'(SCORE_BINS);
		end else if (PW'(x_s3) >= thr) begin
			bin = nxt;
		end else begin
			bin = SB_W'(q0_s3);
		end
	end

endmodule

[rtl/ssh_front.sv]
module ssh_front #(
	parameter int CLASS_COUNT = 3,
	parameter int SCORE_BINS = 50,
	parameter int COUNT_RANGE = 500,
	parameter int MAX_IMAGE_PIXELS = 1048576,
	localparam int CLS_W = $clog2(CLASS_COUNT),
	localparam int SBIN_W = $clog2(SCORE_BINS),
	localparam int CR_W = $clog2(COUNT_RANGE)
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic vld,
	input ssh_pkg::item_t item,
	input logic signed [15:0] thresh,
	output logic above,
	output logic [CLS_W-1:0] best,
	output logic [CLASS_COUNT-1:0][SBIN_W-1:0] sbin,
	output logic [CLASS_COUNT-1:0][CR_W-1:0] ncnt,
	output logic [CLASS_COUNT-1:0] ovf,
	output logic [31:0] img_count
);

	localparam int CNT_W = $clog2(MAX_IMAGE_PIXELS + 1);
	localparam int MW = (CNT_W > CR_W + 1) ? CNT_W : CR_W + 1;
	localparam int SB_W = $clog2(SCORE_BINS + 1);

	logic [15:0] sc [CLASS_COUNT];
	logic [15:0] best_s;
	logic pixel;
	logic hit;
	logic [CNT_W-1:0] cls_cnt_q [CLASS_COUNT];
	logic [CNT_W-1:0] cls_nx [CLASS_COUNT];
	logic [CNT_W-1:0] abv_cnt_q;
	logic [CNT_W-1:0] abv_nx;

	assign above = $signed(item.pixel_value) > thresh;
	assign pixel = vld && (item.kind == ssh_pkg::KIND_PIXEL);
	assign hit = pixel && above;

	for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_cls
		logic [15:0] clamped;
		logic [15+SB_W:0] prod;
		logic [MW-1:0] ext;

		// Classes past the carried scores see a score of zero.
		if (g < ssh_pkg::NUM_SCORES_IN) begin : g_in
			assign sc[g] = item.score[g];
		end else begin : g_zero
			assign sc[g] = '0;
		end

		assign clamped = (sc[g] > ssh_pkg::CLAMP_Q16) ? ssh_pkg::CLAMP_Q16 : sc[g];
		assign prod = clamped * SB_W'(SCORE_BINS);
		assign sbin[g] = prod[ssh_pkg::SCORE_FRAC_W +: SBIN_W];

		assign cls_nx[g] = (hit && (best == CLS_W'(g)) &&
			(cls_cnt_q[g] < CNT_W'(MAX_IMAGE_PIXELS))) ? cls_cnt_q[g] + 1'b1 : cls_cnt_q[g];
		assign ext = MW'(cls_nx[g]);
		assign ovf[g] = ext >= MW'(COUNT_RANGE);
		assign ncnt[g] = ext[CR_W-1:0];
	end

	// Strict compare starting from zero, so ties keep the lower class.
	always_comb begin
		best_s = '0;
		best = '0;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			if (sc[c] > best_s) begin
				best_s = sc[c];
				best = CLS_W'(c);
			end
		end
	end

	assign abv_nx = (hit && (abv_cnt_q < CNT_W'(MAX_IMAGE_PIXELS))) ?
		abv_cnt_q + 1'b1 : abv_cnt_q;
	assign img_count = 32'(abv_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abv_cnt_q <= '0;
			for (int c = 0; c < CLASS_COUNT; c++) begin
				cls_cnt_q[c] <= '0;
			end
		end else if (adv && pixel) begin
			if (item.last) begin
				abv_cnt_q <= '0;
				for (int c = 0; c < CLASS_COUNT; c++) begin
					cls_cnt_q[c] <= '0;
				end
			end else begin
				abv_cnt_q <= abv_nx;
				for (int c = 0; c < CLASS_COUNT; c++) begin
					cls_cnt_q[c] <= cls_nx[c];
				end
			end
		end
	end

endmodule

[rtl/segmentation_score_histogrammer.sv]
// Channel  Direction  Handshake                Content
// s_*      in         s_tvalid / s_tready      pixel transaction or histogram bin read
// m_*      out        m_tvalid / m_tready      image count or bin read data
// cfg_*    in         cfg_valid / cfg_ready    pixel threshold
//
// One item per clock while the output buffer has room. Each histogram bin lives in a
// per-class RAM with a registered read; the update is read, increment, write back, with
// the previous write forwarded. A result is pushed into the output buffer from stage 4.
// Reset clears per-entry valid bits, so histograms read zero at once with no clearing pass.
// The pipeline advances as a whole while the two-entry output buffer has room.
module segmentation_score_histogrammer #(
	parameter int SCORE_BINS = 50,
	parameter int CLASS_COUNT = 3,
	parameter int COUNT_RANGE = 500,
	parameter int MAX_IMAGE_PIXELS = 1048576
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// pixel_value[15:0], score_background[31:16], score_shower[47:32],
	// score_track[63:48], read_set[65:64], read_class[67:66], read_bin[73:68]
	input logic [79:0] s_tdata,
	input logic s_tlast,
	// kind
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// count_value
	output logic [31:0] m_tdata,
	// result_kind
	output logic m_tuser,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic signed [15:0] cfg_data
);

	localparam int CLS_W = $clog2(CLASS_COUNT);
	localparam int SBIN_W = $clog2(SCORE_BINS);
	localparam int PBIN_W = $clog2(SCORE_BINS + 1);
	localparam int CR_W = $clog2(COUNT_RANGE);
	localparam int RB_W = (PBIN_W > 6) ? PBIN_W : 6;
	localparam int CLAMP_BIN_I = (int'(ssh_pkg::CLAMP_Q16) * SCORE_BINS) >> 16;
	localparam logic [SBIN_W-1:0] CLAMP_BIN = SBIN_W'(CLAMP_BIN_I);

	logic adv;
	logic signed [15:0] thresh_q;
	ssh_pkg::item_t item_in;

	// Stage 1
	logic vld_s1;
	ssh_pkg::item_t item_s1;
	logic f_above;
	logic [CLS_W-1:0] f_best;
	logic [CLASS_COUNT-1:0][SBIN_W-1:0] f_sbin;
	logic [CLASS_COUNT-1:0][CR_W-1:0] f_ncnt;
	logic [CLASS_COUNT-1:0] f_ovf;
	logic [31:0] f_img;

	// Stage 2
	logic vld_s2, kind_s2, last_s2, above_s2;
	logic [CLS_W-1:0] best_s2;
	logic [CLASS_COUNT-1:0][SBIN_W-1:0] sbin_s2;
	logic [CLASS_COUNT-1:0][CR_W-1:0] ncnt_s2;
	logic [CLASS_COUNT-1:0] ovf_s2;
	logic [31:0] img_s2;
	logic [1:0] rset_s2, rcls_s2;
	logic [5:0] rbin_s2;

	// Stage 3
	logic vld_s3, kind_s3, last_s3, above_s3;
	logic [CLS_W-1:0] best_s3;
	logic [CLASS_COUNT-1:0][SBIN_W-1:0] sbin_s3;
	logic [PBIN_W-1:0] cbin_s3 [CLASS_COUNT];
	logic [31:0] img_s3;
	logic [1:0] rset_s3, rcls_s3;
	logic [5:0] rbin_s3;
	logic pix3, rd3, rd_ok3;
	logic [RB_W-1:0] rbin_ext;
	logic [CLASS_COUNT-1:0] mc_inc;

	// Stage 4
	logic vld_s4, kind_s4, last_s4, rd_ok_s4;
	logic [1:0] rset_s4, rcls_s4;
	logic [31:0] img_s4;
	logic [ssh_pkg::HIST_W-1:0] mc_data [CLASS_COUNT];
	logic [ssh_pkg::HIST_W-1:0] at_data [CLASS_COUNT];
	logic [ssh_pkg::HIST_W-1:0] pp_data [CLASS_COUNT];
	logic [ssh_pkg::HIST_W-1:0] sel;
	ssh_pkg::result_t res;
	logic push, pop;

	// Output buffer
	logic [1:0] ocnt_q;
	ssh_pkg::result_t ob0_q, ob1_q;

	assign adv = (ocnt_q != 2'd2);
	assign s_tready = adv;
	assign cfg_ready = 1'b1;

	assign item_in.kind = s_tuser;
	assign item_in.pixel_value = s_tdata[15:0];
	assign item_in.score[0] = s_tdata[31:16];
	assign item_in.score[1] = s_tdata[47:32];
	assign item_in.score[2] = s_tdata[63:48];
	assign item_in.last = s_tlast;
	assign item_in.read_set = s_tdata[65:64];
	assign item_in.read_class = s_tdata[67:66];
	assign item_in.read_bin = s_tdata[73:68];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg_valid) begin
			thresh_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	ssh_front #(
		.CLASS_COUNT(CLASS_COUNT),
		.SCORE_BINS(SCORE_BINS),
		.COUNT_RANGE(COUNT_RANGE),
		.MAX_IMAGE_PIXELS(MAX_IMAGE_PIXELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.vld(vld_s1),
		.item(item_s1),
		.thresh(thresh_q),
		.above(f_above),
		.best(f_best),
		.sbin(f_sbin),
		.ncnt(f_ncnt),
		.ovf(f_ovf),
		.img_count(f_img)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_in;

			kind_s2 <= item_s1.kind;
			last_s2 <= item_s1.last;
			above_s2 <= f_above;
			best_s2 <= f_best;
			sbin_s2 <= f_sbin;
			ncnt_s2 <= f_ncnt;
			ovf_s2 <= f_ovf;
			img_s2 <= f_img;
			rset_s2 <= item_s1.read_set;
			rcls_s2 <= item_s1.read_class;
			rbin_s2 <= item_s1.read_bin;

			kind_s3 <= kind_s2;
			last_s3 <= last_s2;
			above_s3 <= above_s2;
			best_s3 <= best_s2;
			sbin_s3 <= sbin_s2;
			img_s3 <= img_s2;
			rset_s3 <= rset_s2;
			rcls_s3 <= rcls_s2;
			rbin_s3 <= rbin_s2;

			kind_s4 <= kind_s3;
			last_s4 <= last_s3;
			rd_ok_s4 <= rd_ok3;
			rset_s4 <= rset_s3;
			rcls_s4 <= rcls_s3;
			img_s4 <= img_s3;
		end
	end

	assign pix3 = vld_s3 && (kind_s3 == ssh_pkg::KIND_PIXEL);
	assign rd3 = vld_s3 && (kind_s3 == ssh_pkg::KIND_READ);
	assign rbin_ext = RB_W'(rbin_s3);

	always_comb begin
		rd_ok3 = 1'b0;
		if (32'(rcls_s3) < CLASS_COUNT) begin
			if ((rset_s3 == ssh_pkg::SET_MAX_CLASS) || (rset_s3 == ssh_pkg::SET_ABOVE)) begin
				rd_ok3 = rbin_ext < RB_W'(SCORE_BINS);
			end else if (rset_s3 == ssh_pkg::SET_PER_IMAGE) begin
				rd_ok3 = rbin_ext <= RB_W'(SCORE_BINS);
			end
		end
	end

	for (genvar c = 0; c < CLASS_COUNT; c++) begin : g_lane
		logic [SBIN_W-1:0] mc_addr;
		logic [SBIN_W-1:0] at_addr;
		logic [PBIN_W-1:0] pp_addr;
		logic at_inc;
		logic pp_inc;

		ssh_cbin #(
			.SCORE_BINS(SCORE_BINS),
			.COUNT_RANGE(COUNT_RANGE)
		) u_cbin (
			.clk(clk),
			.adv(adv),
			.n(ncnt_s2[c]),
			.ovf(ovf_s2[c]),
			.bin(cbin_s3[c])
		);

		// A pixel at or below threshold lands in the background clamp bin.
		assign mc_inc[c] = pix3 && (above_s3 ? (best_s3 == CLS_W'(c)) : (c == 0));
		assign mc_addr = rd3 ? rbin_ext[SBIN_W-1:0] : (above_s3 ? sbin_s3[c] : CLAMP_BIN);
		assign at_inc = pix3 && above_s3;
		assign at_addr = rd3 ? rbin_ext[SBIN_W-1:0] : sbin_s3[c];
		assign pp_inc = pix3 && last_s3;
		assign pp_addr = rd3 ? rbin_ext[PBIN_W-1:0] : cbin_s3[c];

		ssh_bank #(.DEPTH(SCORE_BINS)) u_mc (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.inc(mc_inc[c]),
			.addr(mc_addr),
			.data(mc_data[c])
		);

		ssh_bank #(.DEPTH(SCORE_BINS)) u_at (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.inc(at_inc),
			.addr(at_addr),
			.data(at_data[c])
		);

		ssh_bank #(.DEPTH(SCORE_BINS + 1)) u_pp (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.inc(pp_inc),
			.addr(pp_addr),
			.data(pp_data[c])
		);
	end

	always_comb begin
		sel = '0;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			if (32'(rcls_s4) == c) begin
				case (rset_s4)
					ssh_pkg::SET_MAX_CLASS: sel = mc_data[c];
					ssh_pkg::SET_ABOVE: sel = at_data[c];
					ssh_pkg::SET_PER_IMAGE: sel = pp_data[c];
					default: sel = '0;
				endcase
			end
		end
	end

	always_comb begin
		if (kind_s4 == ssh_pkg::KIND_READ) begin
			res.kind = ssh_pkg::RES_BIN;
			res.count = rd_ok_s4 ? sel : '0;
		end else begin
			res.kind = ssh_pkg::RES_IMAGE;
			res.count = img_s4;
		end
	end

	assign push = adv && vld_s4 && ((kind_s4 == ssh_pkg::KIND_READ) || last_s4);
	assign pop = (ocnt_q != 2'd0) && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 2'd0;
		end else begin
			ocnt_q <= ocnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && ((ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && pop))) begin
			ob0_q <= res;
		end else if (pop) begin
			ob0_q <= ob1_q;
		end
		if (push && (ocnt_q == 2'd1) && !pop) begin
			ob1_q <= res;
		end
	end

	assign m_tvalid = (ocnt_q != 2'd0);
	assign m_tdata = ob0_q.count;
	assign m_tuser = ob0_q.kind;

	// The input side only stalls when two results are waiting.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && (ocnt_q == 2'd2)))
		else $error("input stalled without a full output buffer");

	// Every pixel transaction bumps exactly one max-class histogram lane.
	a_mc_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		pix3 |-> $onehot(mc_inc))
		else $error("max-class update not on exactly one class");

	// Closing an image always leaves a result for the output side.
	a_image_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s4 && (kind_s4 == ssh_pkg::KIND_PIXEL) && last_s4) |=> m_tvalid)
		else $error("image end produced no result");

	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("output buffer count out of range");

endmodule
